>>> rtl/core/swp_pkg.sv
`timescale 1ns / 1ps

package swp_pkg;

    localparam int WORD_W      = 32;
    localparam int SHIFT_W     = 5;
    localparam int SUB_W       = SHIFT_W + 1;
    localparam int POS_W       = 7;
    localparam int READ_ADDR_W = 7;
    // Wide enough for any buffer address up to 16 blocks of 16 words
    localparam int MEM_ADDR_W  = 8;

    typedef enum logic [1:0] {
        OP_ITEM    = 2'd0,
        OP_CONST   = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef struct packed {
        op_t                    operation;
        logic [WORD_W-1:0]      word;
        logic [WORD_W-1:0]      front_pad;
        logic [WORD_W-1:0]      back_pad;
        logic [SHIFT_W-1:0]     shift;
        logic [SHIFT_W-1:0]     tail_bits;
        logic                   overflow;
        logic                   first;
        logic                   last;
        logic [READ_ADDR_W-1:0] read_address;
    } item_t;

    // Memory work and result fields for one request
    typedef struct packed {
        logic                  rd_valid;
        logic                  or_mode;
        logic                  w0_en;
        logic [MEM_ADDR_W-1:0] w0_addr;
        logic [WORD_W-1:0]     w0_data;
        logic                  w1_en;
        logic [MEM_ADDR_W-1:0] w1_addr;
        logic [WORD_W-1:0]     w1_data;
        logic [MEM_ADDR_W-1:0] rd_addr;
        logic [POS_W-1:0]      position;
        logic [SHIFT_W-1:0]    pending;
        logic                  error;
    } cmd_t;

    // Right shift where 32 or more gives zero
    function automatic logic [WORD_W-1:0] shr_word(input logic [WORD_W-1:0] v,
                                                   input logic [SUB_W-1:0] s);
        return s[SUB_W-1] ? '0 : (v >> s[SHIFT_W-1:0]);
    endfunction

    // Bits of v pushed out by a right shift of sub, aligned for the next word
    function automatic logic [WORD_W-1:0] carry_word(input logic [WORD_W-1:0] v,
                                                     input logic [SUB_W-1:0] sub);
        logic [SHIFT_W-1:0] lsh;
        lsh = SHIFT_W'(0) - sub[SHIFT_W-1:0];
        if (sub == '0)
            return '0;
        else if (!sub[SUB_W-1])
            return v << lsh;
        else
            return v >> sub[SHIFT_W-1:0];
    endfunction

endpackage

>>> rtl/core/swp_mem.sv
`timescale 1ns / 1ps

module swp_mem
    import swp_pkg::*;
#(
    parameter int DEPTH = 80
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WORD_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WORD_W-1:0]        rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read returns the contents before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/swp_front.sv
`timescale 1ns / 1ps

module swp_front
    import swp_pkg::*;
#(
    parameter int CAPACITY = 80
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item,
    output cmd_t  cmd
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = ((IW > READ_ADDR_W) ? IW : READ_ADDR_W) + 1;
    localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [IW-1:0]      write_index_reg, write_index_next, idx1, idx2;
    logic [SHIFT_W-1:0] filled_reg, filled_next;
    logic [SHIFT_W-1:0] pstart_reg, pstart_next, pend_eff;
    logic [WORD_W-1:0]  prev_reg, prev_next;
    logic [WORD_W-1:0]  shifted, carry_prev, carry_cur;
    logic [SUB_W-1:0]   sub;
    logic               req0, req1, to_i1;

    always_comb
    begin
        pend_eff   = item.first ? filled_reg : pstart_reg;
        sub        = {1'b0, item.shift} + {1'b0, pend_eff};
        shifted    = shr_word(item.word, sub);
        carry_prev = carry_word(prev_reg, sub);
        carry_cur  = carry_word(item.word, sub);
        // saturating advances from the current index
        idx1 = (write_index_reg < CAP_I) ? write_index_reg + IW'(1) : write_index_reg;
        idx2 = (idx1 < CAP_I) ? idx1 + IW'(1) : idx1;
    end

    always_comb
    begin
        cmd              = '0;
        cmd.rd_addr      = MEM_ADDR_W'(write_index_reg);
        write_index_next = write_index_reg;
        filled_next      = filled_reg;
        prev_next        = prev_reg;
        pstart_next      = pstart_reg;
        req0             = 1'b0;
        req1             = 1'b0;
        to_i1            = 1'b0;

        unique case (item.operation)
            OP_ITEM:
            begin
                pstart_next = pend_eff;
                req0        = 1'b1;
                if (item.first && item.last)
                begin
                    cmd.w0_data = item.front_pad | shifted | ((sub == '0) ? item.back_pad : '0);
                    if (sub != '0)
                    begin
                        req1        = 1'b1;
                        cmd.w1_data = carry_cur | item.back_pad;
                        to_i1       = 1'b1;
                    end
                end
                else if (item.first)
                begin
                    // merge into the partial word, or start a fresh padded one
                    if (pend_eff == '0)
                    begin
                        cmd.w0_data = item.front_pad | shifted;
                    end
                    else
                    begin
                        cmd.w0_data = shifted;
                        cmd.or_mode = 1'b1;
                    end
                    to_i1     = 1'b1;
                    prev_next = item.word;
                end
                else if (!item.last)
                begin
                    cmd.w0_data = carry_prev | shifted;
                    to_i1       = 1'b1;
                    prev_next   = item.word;
                end
                else if (item.overflow)
                begin
                    cmd.w0_data = carry_prev | shifted;
                    req1        = 1'b1;
                    cmd.w1_data = carry_cur | item.back_pad;
                    to_i1       = 1'b1;
                end
                else
                begin
                    cmd.w0_data = carry_prev | shifted | item.back_pad;
                end

                if (item.last)
                begin
                    filled_next = item.tail_bits;
                    if (item.tail_bits == '0)
                        write_index_next = to_i1 ? idx2 : idx1;
                    else
                        write_index_next = to_i1 ? idx1 : write_index_reg;
                end
                else
                begin
                    write_index_next = to_i1 ? idx1 : write_index_reg;
                end
            end
            OP_CONST:
            begin
                req0             = 1'b1;
                cmd.w0_data      = item.word;
                write_index_next = idx1;
            end
            OP_READ:
            begin
                cmd.rd_addr  = MEM_ADDR_W'(item.read_address);
                cmd.rd_valid = CW'(item.read_address) < CAP_C;
            end
            OP_RESTART:
            begin
                write_index_next = '0;
                filled_next      = '0;
                prev_next        = '0;
                pstart_next      = '0;
            end
            default:
            begin
                write_index_next = write_index_reg;
            end
        endcase

        // drop writes that fall past the buffer end and flag them
        cmd.w0_en    = req0 && (write_index_reg < CAP_I);
        cmd.w0_addr  = MEM_ADDR_W'(write_index_reg);
        cmd.w1_en    = req1 && (idx1 < CAP_I);
        cmd.w1_addr  = MEM_ADDR_W'(idx1);
        cmd.error    = (req0 && !(write_index_reg < CAP_I)) || (req1 && !(idx1 < CAP_I));
        cmd.position = POS_W'(write_index_next);
        cmd.pending  = filled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            filled_reg      <= '0;
            prev_reg        <= '0;
            pstart_reg      <= '0;
        end
        else if (accept)
        begin
            write_index_reg <= write_index_next;
            filled_reg      <= filled_next;
            prev_reg        <= prev_next;
            pstart_reg      <= pstart_next;
        end
    end

endmodule

>>> rtl/core/swp_back.sv
`timescale 1ns / 1ps

module swp_back
    import swp_pkg::*;
#(
    parameter int DEPTH = 80
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cmd_t               cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [WORD_W-1:0]  out_read_data,
    output logic [POS_W-1:0]   out_position,
    output logic [SHIFT_W-1:0] out_pending,
    output logic               out_error
);

    localparam int AW = $clog2(DEPTH);

    logic               s2_valid_reg, s2_phase_reg;
    cmd_t               s2_cmd_reg;
    logic               fwd_hit_reg;
    logic [WORD_W-1:0]  fwd_data_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_read_data_reg;
    logic [POS_W-1:0]   out_position_reg;
    logic [SHIFT_W-1:0] out_pending_reg;
    logic               out_error_reg;

    logic               accept, out_free, done, finish;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [WORD_W-1:0]  wdata, mem_rdata, rd_word;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign done     = s2_valid_reg && (s2_phase_reg || !s2_cmd_reg.w1_en);
    assign finish   = done && out_free;
    assign in_ready = !s2_valid_reg || finish;
    assign rd_word  = fwd_hit_reg ? fwd_data_reg : mem_rdata;

    // first write, then the spill word in the spill phase
    always_comb
    begin
        if (!s2_phase_reg)
        begin
            we    = s2_valid_reg && s2_cmd_reg.w0_en && (s2_cmd_reg.w1_en || out_free);
            waddr = s2_cmd_reg.w0_addr[AW-1:0];
            wdata = s2_cmd_reg.or_mode ? (rd_word | s2_cmd_reg.w0_data) : s2_cmd_reg.w0_data;
        end
        else
        begin
            we    = s2_valid_reg && s2_cmd_reg.w1_en && out_free;
            waddr = s2_cmd_reg.w1_addr[AW-1:0];
            wdata = s2_cmd_reg.w1_data;
        end
    end

    swp_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (cmd.rd_addr[AW-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_phase_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s2_valid_reg <= 1'b1;
            s2_phase_reg <= 1'b0;
            // the memory read misses a write landing at the same edge
            fwd_hit_reg  <= we && (waddr == cmd.rd_addr[AW-1:0]);
        end
        else if (finish)
        begin
            s2_valid_reg <= 1'b0;
            s2_phase_reg <= 1'b0;
        end
        else if (s2_valid_reg && !s2_phase_reg && s2_cmd_reg.w1_en)
        begin
            s2_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_cmd_reg   <= cmd;
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_read_data_reg <= s2_cmd_reg.rd_valid ? rd_word : '0;
            out_position_reg  <= s2_cmd_reg.position;
            out_pending_reg   <= s2_cmd_reg.pending;
            out_error_reg     <= s2_cmd_reg.error;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_read_data = out_read_data_reg;
    assign out_position  = out_position_reg;
    assign out_pending   = out_pending_reg;
    assign out_error     = out_error_reg;

    a_phase_two_write: assert property (@(posedge clk) disable iff (!rst_n)
        s2_phase_reg |-> (s2_valid_reg && s2_cmd_reg.w1_en))
        else $error("spill phase without a pending second write");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_phase_reg && s2_cmd_reg.w1_en) |=> s2_phase_reg)
        else $error("two-write request did not move to its spill phase");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ({1'b0, waddr} < (AW + 1)'(DEPTH)))
        else $error("buffer write beyond the last word");

    a_read_or_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_cmd_reg.or_mode) |-> !s2_cmd_reg.rd_valid)
        else $error("merge write and buffer read in one request");

endmodule

>>> rtl/core/shifted_word_packer_core.sv
`timescale 1ns / 1ps

// Timing: a request is registered into the memory stage, then its result into the
//   output register; one that writes two buffer words (overflow or single-word
//   spill) holds the single memory write port through a spill phase before output.
// Throughput: one request per cycle unless the output stalls or a spill phase runs.
// Reset: rst_n clears the index, shift and previous-word state and all valid flags
//   at once; buffer contents are not cleared and a word is undefined until written.
module shifted_word_packer_core
    import swp_pkg::*;
#(
    parameter int BLOCKS          = 5,
    parameter int WORDS_PER_BLOCK = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // word[31:0], front_pad[63:32], back_pad[95:64], shift[100:96],
    // tail_bits[105:101], overflow[106], read_address[113:107], zero[119:114]
    input  logic [119:0] s_tdata,
    // operation[1:0], first[2]
    input  logic [2:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[31:0], position[38:32], pending_shift[43:39], error[44], zero[47:45]
    output logic [47:0]  m_tdata
);

    localparam int CAPACITY = BLOCKS * WORDS_PER_BLOCK;

    item_t              item;
    cmd_t               cmd;
    logic               accept;
    logic [WORD_W-1:0]  read_data;
    logic [POS_W-1:0]   position;
    logic [SHIFT_W-1:0] pending_shift;
    logic               error;

    // Unpack the request fields from the stream
    always_comb
    begin
        item.operation    = op_t'(s_tuser[1:0]);
        item.first        = s_tuser[2];
        item.last         = s_tlast;
        item.word         = s_tdata[31:0];
        item.front_pad    = s_tdata[63:32];
        item.back_pad     = s_tdata[95:64];
        item.shift        = s_tdata[100:96];
        item.tail_bits    = s_tdata[105:101];
        item.overflow     = s_tdata[106];
        item.read_address = s_tdata[113:107];
    end

    assign accept = s_tvalid && s_tready;

    // Front end: hold the packing state and turn each request into memory work
    swp_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (cmd)
    );

    // Back end: read-modify-write the buffer, forward a colliding write, and
    // register the result; a stalled output blocks new requests once the memory stage is full
    swp_back #(
        .DEPTH (CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .cmd           (cmd),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_read_data (read_data),
        .out_position  (position),
        .out_pending   (pending_shift),
        .out_error     (error)
    );

    assign m_tdata = {3'b000, error, pending_shift, position, read_data};

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import swp_pkg::*;

    localparam int BLOCKS          = 5;
    localparam int WORDS_PER_BLOCK = 16;
    localparam int CAPACITY        = BLOCKS * WORDS_PER_BLOCK;
    localparam int TOTAL_REQUESTS  = 450;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [31:0] read_data;
        logic [6:0]  position;
        logic [4:0]  pending_shift;
        logic        error;
    } reply_t;

    typedef struct packed {
        item_t  req;
        logic   typed;
        reply_t want;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    // Shadow of the packer state
    logic [31:0] shadow_mem [CAPACITY];
    logic        shadow_known [CAPACITY];
    logic [6:0]  next_index;
    logic [4:0]  filled;
    logic [31:0] last_elem;
    logic [4:0]  item_pend;
    logic        dropped_flag;

    reply_t expected_q [$];
    int     sent = 0;
    int     results_seen = 0;
    int     mismatches = 0;
    int     burst_left = 0;
    bit     hold_off_go = 1'b0;

    shifted_word_packer_core #(
        .BLOCKS          (BLOCKS),
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Directed requests: fields are
    // operation, word, front_pad, back_pad, shift, tail_bits, overflow, first, last, read_address
    // expectations are read_data, position, pending_shift, error
    localparam row_t PLAN [0:23] = '{
        // reads after reset, out of range
        '{'{OP_READ, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd127},
          1'b1, '{32'h0, 7'd0, 5'd0, 1'b0}},
        '{'{OP_READ, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd80},
          1'b1, '{32'h0, 7'd0, 5'd0, 1'b0}},
        '{'{OP_CONST, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0},
          1'b1, '{32'h0, 7'd1, 5'd0, 1'b0}},
        '{'{OP_CONST, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0},
          1'b1, '{32'h0, 7'd2, 5'd0, 1'b0}},
        // single element, no shift: back padding ORed into the same word
        '{'{OP_ITEM, 32'hA5A5_0F0F, 32'h8000_0000, 32'h0000_0030, 5'd0, 5'd0, 1'b1, 1'b1, 1'b1,
            7'd0}, 1'b0, '0},
        // single element, maximum shift, spill into the next word
        '{'{OP_ITEM, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 5'd31, 5'd31, 1'b0, 1'b1, 1'b1,
            7'd0}, 1'b0, '0},
        // three elements, the first ORed into the partial word, overflow on the last
        '{'{OP_ITEM, 32'h1234_5678, 32'hFFFF_0000, 32'h0, 5'd0, 5'd0, 1'b0, 1'b1, 1'b0, 7'd0},
          1'b0, '0},
        '{'{OP_ITEM, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0},
          1'b0, '0},
        '{'{OP_ITEM, 32'h8000_0001, 32'h0, 32'hF000_0000, 5'd0, 5'd0, 1'b1, 1'b0, 1'b1, 7'd0},
          1'b0, '0},
        // front padding, then a partial last word
        '{'{OP_ITEM, 32'hDEAD_BEEF, 32'h0000_00FF, 32'h0, 5'd8, 5'd0, 1'b0, 1'b1, 1'b0, 7'd0},
          1'b0, '0},
        '{'{OP_ITEM, 32'hCAFE_F00D, 32'h0, 32'h0000_0001, 5'd8, 5'd17, 1'b0, 1'b0, 1'b1, 7'd0},
          1'b0, '0},
        // elements with no first mark carry on from the stored state
        '{'{OP_ITEM, 32'h0F0F_0F0F, 32'h0, 32'h0, 5'd8, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0},
          1'b0, '0},
        '{'{OP_ITEM, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd0, 5'd0, 1'b1, 1'b0, 1'b1, 7'd0},
          1'b0, '0},
        '{'{OP_READ, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0}, 1'b0, '0},
        '{'{OP_READ, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd4}, 1'b0, '0},
        '{'{OP_RESTART, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0},
          1'b1, '{32'h0, 7'd0, 5'd0, 1'b0}},
        // total shift past 32 bits
        '{'{OP_ITEM, 32'h8000_0000, 32'h0, 32'h0, 5'd31, 5'd31, 1'b0, 1'b1, 1'b1, 7'd0},
          1'b0, '0},
        '{'{OP_ITEM, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd31, 5'd0, 1'b0, 1'b1, 1'b0, 7'd0},
          1'b0, '0},
        '{'{OP_ITEM, 32'h0, 32'h0, 32'h0, 5'd31, 5'd31, 1'b0, 1'b0, 1'b1, 7'd0}, 1'b0, '0},
        // total shift of exactly 32 bits
        '{'{OP_ITEM, 32'hAAAA_AAAA, 32'h0, 32'h0, 5'd1, 5'd0, 1'b0, 1'b1, 1'b0, 7'd0},
          1'b0, '0},
        '{'{OP_ITEM, 32'h5555_5555, 32'h0, 32'h0, 5'd1, 5'd5, 1'b1, 1'b0, 1'b1, 7'd0},
          1'b0, '0},
        // constant word leaves the pending shift alone
        '{'{OP_CONST, 32'h0123_4567, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd0},
          1'b0, '0},
        '{'{OP_READ, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd3}, 1'b0, '0},
        '{'{OP_READ, 32'h0, 32'h0, 32'h0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 7'd2}, 1'b0, '0}
    };

    function automatic logic [31:0] shr(input logic [31:0] v, input logic [5:0] s);
        return (s >= 6'd32) ? 32'h0 : (v >> s);
    endfunction

    // Bits pushed out by a right shift of s, aligned for the following word
    function automatic logic [31:0] spill(input logic [31:0] v, input logic [5:0] s);
        if (s == 6'd0)
            return 32'h0;
        else if (s == 6'd32)
            return v;
        else if (s < 6'd32)
            return v << (6'd32 - s);
        else
            return v >> (s - 6'd32);
    endfunction

    function automatic void store_word(input logic [31:0] v);
        if (next_index < CAPACITY)
        begin
            shadow_mem[next_index]   = v;
            shadow_known[next_index] = 1'b1;
        end
        else
            dropped_flag = 1'b1;
    endfunction

    function automatic void merge_word(input logic [31:0] v);
        if (next_index < CAPACITY)
            shadow_mem[next_index] |= v;
        else
            dropped_flag = 1'b1;
    endfunction

    function automatic void step_index();
        if (next_index < CAPACITY)
            next_index++;
    endfunction

    // Advance the shadow state by one request and return its reply
    function automatic reply_t pack_reply(input item_t r);
        reply_t     o;
        logic [5:0] sub;
        o = '0;
        dropped_flag = 1'b0;
        case (r.operation)
            OP_ITEM:
            begin
                if (r.first)
                    item_pend = filled;
                sub = {1'b0, r.shift} + {1'b0, item_pend};
                if (r.first && r.last)
                begin
                    store_word(r.front_pad | shr(r.word, sub));
                    if (sub != 6'd0)
                    begin
                        step_index();
                        store_word(spill(r.word, sub) | r.back_pad);
                    end
                    else
                        merge_word(r.back_pad);
                end
                else if (r.first)
                begin
                    if (item_pend == 5'd0)
                        store_word(r.front_pad | shr(r.word, sub));
                    else
                        merge_word(shr(r.word, sub));
                    step_index();
                    last_elem = r.word;
                end
                else if (!r.last)
                begin
                    store_word(spill(last_elem, sub) | shr(r.word, sub));
                    step_index();
                    last_elem = r.word;
                end
                else if (r.overflow)
                begin
                    store_word(spill(last_elem, sub) | shr(r.word, sub));
                    step_index();
                    store_word(spill(r.word, sub) | r.back_pad);
                end
                else
                    store_word(spill(last_elem, sub) | shr(r.word, sub) | r.back_pad);
                if (r.last)
                begin
                    if (r.tail_bits == 5'd0)
                        step_index();
                    filled = r.tail_bits;
                end
            end
            OP_CONST:
            begin
                store_word(r.word);
                step_index();
            end
            OP_READ:
            begin
                if (r.read_address < CAPACITY)
                    o.read_data = shadow_mem[r.read_address];
            end
            default:
            begin
                next_index = '0;
                filled     = '0;
                last_elem  = '0;
                item_pend  = '0;
            end
        endcase
        o.position      = next_index;
        o.pending_shift = filled;
        o.error         = dropped_flag;
        return o;
    endfunction

    // Offer one request at the falling edge, hold it until taken
    task automatic push_request(input item_t r, input logic typed, input reply_t want);
        int     gap;
        reply_t pred;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, r.read_address, r.overflow, r.tail_bits, r.shift,
                    r.back_pad, r.front_pad, r.word};
        s_tuser  = {r.first, r.operation};
        s_tlast  = r.last;
        do
            @(posedge clk);
        while (!s_tready);
        pred = pack_reply(r);
        expected_q.push_back(typed ? want : pred);
        sent++;
        @(negedge clk);
    endtask

    function automatic item_t scramble();
        item_t r;
        r.operation    = op_t'($urandom_range(0, 3));
        r.word         = $urandom;
        r.front_pad    = $urandom;
        r.back_pad     = $urandom;
        r.shift        = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0, 1:    r.tail_bits = 5'd0;
            2:       r.tail_bits = 5'd31;
            default: r.tail_bits = 5'($urandom_range(0, 31));
        endcase
        r.overflow     = 1'($urandom_range(0, 1));
        r.first        = 1'($urandom_range(0, 1));
        r.last         = 1'($urandom_range(0, 1));
        r.read_address = 7'($urandom_range(0, 127));
        return r;
    endfunction

    // Drop in a restart where an item start would OR into a word never written
    task automatic offer(input item_t r);
        item_t clr;
        if (r.operation == OP_ITEM && r.first && !r.last && filled != 5'd0 &&
            next_index < CAPACITY && !shadow_known[next_index])
        begin
            clr = scramble();
            clr.operation = OP_RESTART;
            push_request(clr, 1'b0, '0);
        end
        push_request(r, 1'b0, '0);
    endtask

    task automatic random_traffic();
        item_t      r;
        int         kind;
        int         n;
        int         tries;
        logic [6:0] a;
        while (sent < TOTAL_REQUESTS)
        begin
            kind = $urandom_range(0, 99);
            r = scramble();
            if (kind < 60)
            begin
                n = ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(2, 5);
                for (int e = 0; e < n; e++)
                begin
                    r = scramble();
                    r.operation = OP_ITEM;
                    r.first     = (e == 0);
                    r.last      = (e == n - 1);
                    offer(r);
                end
            end
            else if (kind < 72)
            begin
                r.operation = OP_CONST;
                offer(r);
            end
            else if (kind < 86)
            begin
                r.operation = OP_READ;
                a = 7'($urandom_range(CAPACITY, 127));
                if ($urandom_range(0, 4) != 0)
                begin
                    tries = 0;
                    a = 7'($urandom_range(0, CAPACITY - 1));
                    while (!shadow_known[a] && tries < 16)
                    begin
                        a = 7'($urandom_range(0, CAPACITY - 1));
                        tries++;
                    end
                    if (!shadow_known[a])
                        a = 7'($urandom_range(CAPACITY, 127));
                end
                r.read_address = a;
                offer(r);
            end
            else if (kind < 88)
            begin
                r.operation = OP_RESTART;
                offer(r);
            end
            else
            begin
                // stray element with random marks
                r.operation = OP_ITEM;
                offer(r);
            end
        end
    endtask

    // Receiver: runs of full, random and sparse acceptance, one long hold-off
    initial
    begin
        int mode;
        int len;
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off_go && !held)
            begin
                held = 1'b1;
                @(negedge clk);
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(8, 60);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.read_data     = m_tdata[31:0];
            got.position      = m_tdata[38:32];
            got.pending_shift = m_tdata[43:39];
            got.error         = m_tdata[44];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing expected: data %h pos %0d pend %0d err %b",
                             results_seen, got.read_data, got.position, got.pending_shift,
                             got.error);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.read_data != want.read_data || got.position != want.position ||
                    got.pending_shift != want.pending_shift || got.error != want.error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected data %h pos %0d pend %0d err %b,",
                                 results_seen, want.read_data, want.position,
                                 want.pending_shift, want.error,
                                 " got data %h pos %0d pend %0d err %b",
                                 got.read_data, got.position, got.pending_shift,
                                 got.error);
                end
            end
            results_seen++;
        end
    end

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            shadow_mem[i]   = '0;
            shadow_known[i] = 1'b0;
        end
        next_index = '0;
        filled     = '0;
        last_elem  = '0;
        item_pend  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (PLAN[i])
            push_request(PLAN[i].req, PLAN[i].typed, PLAN[i].want);
        hold_off_go = 1'b1;
        random_traffic();
        s_tvalid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
rtl/core/swp_pkg.sv
rtl/core/swp_mem.sv
rtl/core/swp_front.sv
rtl/core/swp_back.sv
rtl/core/shifted_word_packer_core.sv
verif/tb.sv
